// ----- rtl/ed_pkg.sv -----
// Shared constants and types of the Euclidean distance pipeline.
package ed_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam int DIST_BITS = 17;
  localparam int DIST_MAX  = (1 << DIST_BITS) - 1;

  // A square of a clipped gap, and the sum of three of them.
  localparam int SQ_BITS  = 2 * DIST_BITS;
  localparam int SUM_BITS = SQ_BITS + 2;

  // The root of the sum takes one result bit per pipeline stage.
  localparam int ROOT_BITS = SUM_BITS / 2;
  localparam int REM_BITS  = ROOT_BITS + 2;

  typedef enum logic [1:0] {
    DIM_ONE   = 2'd0,
    DIM_TWO   = 2'd1,
    DIM_THREE = 2'd2
  } dim_t;

  typedef struct packed {
    logic                 sat;
    logic [DIST_BITS-1:0] gx;
    logic [DIST_BITS-1:0] gy;
    logic [DIST_BITS-1:0] gz;
  } gap_t;

  typedef struct packed {
    logic                sat;
    logic [SUM_BITS-1:0] sum;
  } sum_t;

endpackage

// ----- rtl/ed_in_if.sv -----
// Input channel: dimension selector and the coordinates of two points.
interface ed_in_if #(
  parameter int COORD_BITS = ed_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] first_z;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic signed [COORD_BITS-1:0] second_z;

  modport source (
    output valid, opcode, first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );

  modport sink (
    input  valid, opcode, first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

// ----- rtl/ed_out_if.sv -----
// Output channel: the distance between the two points of one item.
interface ed_out_if;
  logic                         valid;
  logic                         ready;
  logic [ed_pkg::DIST_BITS-1:0] distance;

  modport source (
    output valid, distance,
    input  ready
  );

  modport sink (
    input  valid, distance,
    output ready
  );
endinterface

// ----- rtl/euclidean_distance_1d_2d_3d_top.sv -----
// Top level of the Euclidean distance pipeline for one-, two- and three-dimensional points.
//
// Each transfer on item carries a dimension selector and two points in signed
// fixed point with four fraction bits; one transfer on result follows with the
// floor of the distance between them, unsigned with four fraction bits, in the
// order the items came in. A one-dimensional item gives the absolute x
// difference, y and z are ignored where the selector does not use them, and the
// unused selector code behaves as three-dimensional. A distance that does not
// fit in 17 bits, possible only with coordinates wider than 16 bits, saturates
// to the largest code. The block takes one item per clock cycle while the
// output buffer has room. An item passes through registers for the axis gaps,
// the squares and their sum, then through the square root stages, which settle
// one root bit per stage; its result then goes into the output buffer. A two-entry buffer
// sits at the output, so the pipeline and the input keep moving while one result
// waits to be taken, and they pause only when both entries are full. No state is
// kept between items, and reset only empties the pipeline and the output buffer.
module euclidean_distance_1d_2d_3d_top #(
  parameter int COORD_BITS = ed_pkg::COORD_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  ed_in_if.sink   item,
  ed_out_if.source result
);

  // Pipeline advance, set by room in the output buffer.
  logic         adv;
  logic         gap_valid;
  ed_pkg::gap_t gap;
  logic         sum_valid;
  ed_pkg::sum_t sum;

  // Gaps of the selected axes, each checked against the distance range.
  ed_gap #(
    .COORD_BITS(COORD_BITS)
  ) u_gap (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .item     (item),
    .gap_valid(gap_valid),
    .gap      (gap)
  );

  // Squares of the gaps and their sum; an unused axis contributes zero.
  ed_square u_square (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .gap_valid(gap_valid),
    .gap      (gap),
    .sum_valid(sum_valid),
    .sum      (sum)
  );

  // Floor of the root of the sum, saturation, and the output buffer.
  ed_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .sum_valid(sum_valid),
    .sum      (sum),
    .result   (result)
  );

endmodule

// ----- rtl/ed_gap.sv -----
// First stage: per-axis gap magnitudes, axis selection and range check.
module ed_gap #(
  parameter int COORD_BITS = ed_pkg::COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  ed_in_if.sink        item,
  output logic         gap_valid,
  output ed_pkg::gap_t gap
);

  localparam int GW = COORD_BITS + 1;
  localparam int XW = (GW > ed_pkg::DIST_BITS) ? GW : ed_pkg::DIST_BITS;

  function automatic logic [XW-1:0] axis_mag(input logic [COORD_BITS-1:0] a,
                                             input logic [COORD_BITS-1:0] b);
    logic signed [GW-1:0] d;
    logic [GW-1:0]        m;
    d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    m = d[GW-1] ? GW'(-d) : GW'(d);
    return XW'(m);
  endfunction

  logic          use_y;
  logic          use_z;
  logic [XW-1:0] mx;
  logic [XW-1:0] my;
  logic [XW-1:0] mz;
  ed_pkg::gap_t  gap_next;

  // Selector code three is taken as three-dimensional.
  assign use_y = (item.opcode != ed_pkg::DIM_ONE);
  assign use_z = (item.opcode != ed_pkg::DIM_ONE) && (item.opcode != ed_pkg::DIM_TWO);

  always_comb begin
    mx = axis_mag(item.first_x, item.second_x);
    my = use_y ? axis_mag(item.first_y, item.second_y) : '0;
    mz = use_z ? axis_mag(item.first_z, item.second_z) : '0;
    gap_next.sat = (mx > XW'(ed_pkg::DIST_MAX)) || (my > XW'(ed_pkg::DIST_MAX)) ||
                   (mz > XW'(ed_pkg::DIST_MAX));
    gap_next.gx  = mx[ed_pkg::DIST_BITS-1:0];
    gap_next.gy  = my[ed_pkg::DIST_BITS-1:0];
    gap_next.gz  = mz[ed_pkg::DIST_BITS-1:0];
  end

  assign item.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_valid <= 1'b0;
    end else if (adv) begin
      gap_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gap <= gap_next;
    end
  end

endmodule

// ----- rtl/ed_square.sv -----
// Second and third stages: squares of the three gaps, then their sum.
module ed_square (
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  logic         gap_valid,
  input  ed_pkg::gap_t gap,
  output logic         sum_valid,
  output ed_pkg::sum_t sum
);

  logic                       sq_valid;
  logic                       sq_sat;
  logic [ed_pkg::SQ_BITS-1:0] sqx;
  logic [ed_pkg::SQ_BITS-1:0] sqy;
  logic [ed_pkg::SQ_BITS-1:0] sqz;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else if (adv) begin
      sq_valid  <= gap_valid;
      sum_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_sat  <= gap.sat;
      sqx     <= ed_pkg::SQ_BITS'(gap.gx) * ed_pkg::SQ_BITS'(gap.gx);
      sqy     <= ed_pkg::SQ_BITS'(gap.gy) * ed_pkg::SQ_BITS'(gap.gy);
      sqz     <= ed_pkg::SQ_BITS'(gap.gz) * ed_pkg::SQ_BITS'(gap.gz);
      sum.sat <= sq_sat;
      sum.sum <= ed_pkg::SUM_BITS'(sqx) + ed_pkg::SUM_BITS'(sqy) +
                 ed_pkg::SUM_BITS'(sqz);
    end
  end

endmodule

// ----- rtl/ed_sqrt.sv -----
// Square root pipeline, one result bit per stage, and the two-entry output buffer.
module ed_sqrt (
  input  logic         clk,
  input  logic         rst,
  output logic         adv,
  input  logic         sum_valid,
  input  ed_pkg::sum_t sum,
  ed_out_if.source     result
);

  localparam int N = ed_pkg::ROOT_BITS;
  localparam logic [1:0] BUF_FULL = 2'd2;

  logic                        v_q      [N];
  logic                        sat_q    [N];
  logic [ed_pkg::REM_BITS-1:0]  rem_q    [N];
  logic [ed_pkg::ROOT_BITS-1:0] root_q   [N];
  logic [ed_pkg::SUM_BITS-1:0]  val_q    [N];

  logic                        v_next   [N];
  logic                        sat_next [N];
  logic [ed_pkg::REM_BITS-1:0]  rem_next [N];
  logic [ed_pkg::ROOT_BITS-1:0] root_next[N];
  logic [ed_pkg::SUM_BITS-1:0]  val_next [N];

  // Each stage brings down the next two bits of the radicand and tries
  // one more root bit against the running remainder.
  always_comb begin
    logic                         p_v;
    logic                         p_sat;
    logic [ed_pkg::REM_BITS-1:0]  p_rem;
    logic [ed_pkg::ROOT_BITS-1:0] p_root;
    logic [ed_pkg::SUM_BITS-1:0]  p_val;
    logic [ed_pkg::REM_BITS+1:0]  cur;
    logic [ed_pkg::REM_BITS+1:0]  trial;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        p_v    = sum_valid;
        p_sat  = sum.sat;
        p_rem  = '0;
        p_root = '0;
        p_val  = sum.sum;
      end else begin
        p_v    = v_q[k-1];
        p_sat  = sat_q[k-1];
        p_rem  = rem_q[k-1];
        p_root = root_q[k-1];
        p_val  = val_q[k-1];
      end
      cur   = {p_rem, p_val[ed_pkg::SUM_BITS-1 -: 2]};
      trial = {2'b00, p_root, 2'b01};
      if (cur >= trial) begin
        rem_next[k]  = ed_pkg::REM_BITS'(cur - trial);
        root_next[k] = {p_root[ed_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_next[k]  = ed_pkg::REM_BITS'(cur);
        root_next[k] = {p_root[ed_pkg::ROOT_BITS-2:0], 1'b0};
      end
      val_next[k] = p_val << 2;
      sat_next[k] = p_sat;
      v_next[k]   = p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 0; k < N; k++) begin
        v_q[k] <= v_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        sat_q[k]  <= sat_next[k];
        rem_q[k]  <= rem_next[k];
        root_q[k] <= root_next[k];
        val_q[k]  <= val_next[k];
      end
    end
  end

  // Output buffer. The pipeline moves whenever the buffer has room, so the
  // input side keeps going while one finished result waits.
  logic [1:0]                   count;
  logic [ed_pkg::DIST_BITS-1:0] entry0;
  logic [ed_pkg::DIST_BITS-1:0] entry1;
  logic [ed_pkg::DIST_BITS-1:0] push_data;
  logic                         push;
  logic                         pop;

  assign adv  = (count != BUF_FULL);
  assign push = adv && v_q[N-1];
  assign pop  = result.valid && result.ready;

  assign push_data = (sat_q[N-1] || (root_q[N-1] > ed_pkg::ROOT_BITS'(ed_pkg::DIST_MAX))) ?
                     ed_pkg::DIST_BITS'(ed_pkg::DIST_MAX) :
                     root_q[N-1][ed_pkg::DIST_BITS-1:0];

  assign result.valid    = (count != 2'd0);
  assign result.distance = entry0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        entry0 <= push_data;
      end else begin
        entry0 <= entry1;
        entry1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        entry0 <= push_data;
      end else begin
        entry1 <= push_data;
      end
    end else if (pop) begin
      entry0 <= entry1;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v_q[N-1] |-> ({1'b0, rem_q[N-1]} <= {2'b00, root_q[N-1], 1'b0}))
    else $error("root remainder exceeds twice the root");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (count == 2'd0) && !result.valid)
    else $error("output buffer not empty after reset");

  a_hold_on_full: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v_q[N-1]) && $stable(root_q[N-1]))
    else $error("last root stage changed while the buffer was full");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == BUF_FULL) |=> (count == BUF_FULL) || (count == 2'd1))
    else $error("output buffer count left its range");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the Euclidean distance pipeline in 1D, 2D and 3D.
`timescale 1ns / 1ps

module testbench;
  import ed_pkg::*;

  localparam int COORD_W     = 16;
  localparam int CLK_HALF    = 6;
  localparam int RESET_TICKS = 6;
  // The pipeline holds 21 items and the output buffer two more, so a hold-off
  // of this length on the result side backs the block up to its input.
  localparam int LONG_HOLD   = 150;
  // This margin covers the drain of the last results at the end.
  localparam int DRAIN_TICKS = 40;
  localparam int PHASES      = 5;
  localparam int PHASE_PAIRS = 196;

  // The selector code that names no dimension; the block treats it as 3D.
  localparam logic [1:0] DIM_SPARE = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [1:0] opcode;
    coord_t     first_x;
    coord_t     first_y;
    coord_t     first_z;
    coord_t     second_x;
    coord_t     second_y;
    coord_t     second_z;
  } pair_t;

  logic clk;
  logic rst;

  ed_in_if #(.COORD_BITS(COORD_W)) item_ch ();
  ed_out_if                        result_ch ();

  euclidean_distance_1d_2d_3d_top #(.COORD_BITS(COORD_W)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // Point pairs waiting to be offered, and the distances owed by the block
  // for pairs it has already taken, oldest first.
  pair_t                pending_pairs[$];
  logic [DIST_BITS-1:0] owed_distances[$];

  // Transfers seen at the last rising edge, for the falling-edge drivers.
  logic in_took;
  logic out_took;

  // Idling controls, set per phase by the stimulus process.
  bit send_idle;
  bit recv_idle;
  int hold_asks;
  int hold_seen;
  int hold_left;
  int send_gap;
  int recv_gap;

  int errors;
  int pairs_taken;
  int distances_checked;
  int dim_count[4];

  // Clock and the single reset at the start of the run. The channel drivers
  // give the block's inputs known values at the first falling edge.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    fork
      forever #CLK_HALF clk = ~clk;
      begin
        repeat (RESET_TICKS) @(negedge clk);
        rst <= 1'b0;
      end
    join_none
  end

  // Absolute difference of two coordinates, wide enough for any input.
  function automatic longint unsigned axis_span(coord_t a, coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? longint'(-d) : longint'(d);
  endfunction

  // Distance the block must return for one pair: the absolute x difference in
  // 1D, otherwise the floor of the root of the summed squared differences.
  // The spare selector code counts as 3D.
  function automatic logic [DIST_BITS-1:0] distance_of(pair_t p);
    longint unsigned gx, gy, gz, sum, root, trial;
    int b;
    gx = axis_span(p.first_x, p.second_x);
    gy = 0;
    gz = 0;
    if (p.opcode != DIM_ONE)
      gy = axis_span(p.first_y, p.second_y);
    if (p.opcode != DIM_ONE && p.opcode != DIM_TWO)
      gz = axis_span(p.first_z, p.second_z);
    if (gx > DIST_MAX || gy > DIST_MAX || gz > DIST_MAX)
      return DIST_BITS'(DIST_MAX);
    if (p.opcode == DIM_ONE)
      return gx[DIST_BITS-1:0];
    sum = gx * gx + gy * gy + gz * gz;
    // Settle the root one bit at a time from the top; the sum stays below 2^36.
    root = 0;
    for (b = 18; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum)
        root = trial;
    end
    if (root > DIST_MAX)
      root = DIST_MAX;
    return root[DIST_BITS-1:0];
  endfunction

  // Wait before the next transfer on one side: none in burst phases, otherwise
  // a mix of back-to-back, short and long gaps.
  function automatic int draw_gap(bit idle);
    if (!idle)
      return 0;
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 11);
    endcase
  endfunction

  // Coordinates lean toward the interesting corners: full random words, the
  // two ends of the range and the values around zero.
  function automatic coord_t random_coord();
    case ($urandom_range(0, 4))
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      2: return coord_t'($urandom_range(0, 64)) - coord_t'(32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Second point is often close to the first, so small distances with all
  // their fraction bits get exercised as well as the far ones.
  function automatic coord_t partner_of(coord_t c);
    if ($urandom_range(0, 2) == 0)
      return c + coord_t'($urandom_range(0, 40)) - coord_t'(20);
    return random_coord();
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    p.opcode   = ($urandom_range(0, 9) == 0) ? DIM_SPARE : 2'($urandom_range(0, 2));
    p.first_x  = random_coord();
    p.first_y  = random_coord();
    p.first_z  = random_coord();
    p.second_x = partner_of(p.first_x);
    p.second_y = partner_of(p.first_y);
    p.second_z = partner_of(p.first_z);
    return p;
  endfunction

  task automatic queue_pair(input logic [1:0] op, input int fx, input int fy, input int fz,
                            input int sx, input int sy, input int sz);
    pair_t p;
    p.opcode   = op;
    p.first_x  = coord_t'(fx);
    p.first_y  = coord_t'(fy);
    p.first_z  = coord_t'(fz);
    p.second_x = coord_t'(sx);
    p.second_y = coord_t'(sy);
    p.second_z = coord_t'(sz);
    pending_pairs.push_back(p);
  endtask

  // Blocks until the sender has nothing left and every owed distance is back.
  task automatic wait_drained();
    while (pending_pairs.size() != 0 || item_ch.valid === 1'b1 || owed_distances.size() != 0)
      @(posedge clk);
  endtask

  // Sender: offers the oldest pending pair at a falling edge and holds it until
  // the transfer, then waits its drawn gap before the next one.
  always @(negedge clk) begin
    pair_t cur;
    if (rst) begin
      item_ch.valid    <= 1'b0;
      item_ch.opcode   <= '0;
      item_ch.first_x  <= '0;
      item_ch.first_y  <= '0;
      item_ch.first_z  <= '0;
      item_ch.second_x <= '0;
      item_ch.second_y <= '0;
      item_ch.second_z <= '0;
    end else if (item_ch.valid && !in_took) begin
      // The offered pair has not been taken yet; keep it on the channel.
    end else if (send_gap != 0) begin
      send_gap = send_gap - 1;
      item_ch.valid <= 1'b0;
    end else if (pending_pairs.size() != 0) begin
      cur = pending_pairs.pop_front();
      item_ch.valid    <= 1'b1;
      item_ch.opcode   <= cur.opcode;
      item_ch.first_x  <= cur.first_x;
      item_ch.first_y  <= cur.first_y;
      item_ch.first_z  <= cur.first_z;
      item_ch.second_x <= cur.second_x;
      item_ch.second_y <= cur.second_y;
      item_ch.second_z <= cur.second_z;
      send_gap = draw_gap(send_idle);
    end else begin
      item_ch.valid <= 1'b0;
    end
  end

  // Receiver: after each transfer it waits its drawn gap before taking the
  // next result. A hold-off requested by the stimulus keeps ready low for a
  // long stretch, counted here, while the sender goes on offering pairs.
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      result_ch.ready <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD - 1;
      result_ch.ready <= 1'b0;
    end else begin
      if (out_took)
        recv_gap = draw_gap(recv_idle);
      if (recv_gap != 0) begin
        recv_gap = recv_gap - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: at each rising edge a taken pair adds its distance to the owed
  // list, and a taken result is checked against the oldest owed distance.
  always @(posedge clk) begin
    pair_t                seen;
    logic [DIST_BITS-1:0] want;
    in_took  <= !rst && item_ch.valid && item_ch.ready;
    out_took <= !rst && result_ch.valid && result_ch.ready;
    if (!rst && item_ch.valid && item_ch.ready) begin
      seen.opcode   = item_ch.opcode;
      seen.first_x  = item_ch.first_x;
      seen.first_y  = item_ch.first_y;
      seen.first_z  = item_ch.first_z;
      seen.second_x = item_ch.second_x;
      seen.second_y = item_ch.second_y;
      seen.second_z = item_ch.second_z;
      owed_distances.push_back(distance_of(seen));
      dim_count[seen.opcode] = dim_count[seen.opcode] + 1;
      pairs_taken = pairs_taken + 1;
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (owed_distances.size() == 0) begin
        $error("distance: no result expected, got %0d", result_ch.distance);
        errors = errors + 1;
      end else begin
        want = owed_distances.pop_front();
        if (result_ch.distance !== want) begin
          $error("distance: expected %0d, actual %0d", want, result_ch.distance);
          errors = errors + 1;
        end
        distances_checked = distances_checked + 1;
      end
    end
  end

  // Stimulus: a directed set of corner cases, then random phases with
  // different idling on each side. Between phases the sender pauses until
  // every owed distance has come back.
  initial begin
    int ph;
    int k;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);

    // Identical points give zero in every dimension, the spare code included.
    queue_pair(DIM_ONE,   0, 0, 0, 0, 0, 0);
    queue_pair(DIM_TWO,   -5, 7, 9, -5, 7, 9);
    queue_pair(DIM_THREE, -32768, -32768, -32768, -32768, -32768, -32768);
    queue_pair(DIM_SPARE, 32767, 32767, 32767, 32767, 32767, 32767);
    // Widest gaps in both directions along each axis.
    queue_pair(DIM_ONE,   -32768, 0, 0, 32767, 0, 0);
    queue_pair(DIM_ONE,   32767, 0, 0, -32768, 0, 0);
    queue_pair(DIM_TWO,   -32768, 32767, 0, 32767, -32768, 0);
    queue_pair(DIM_THREE, -32768, -32768, -32768, 32767, 32767, 32767);
    queue_pair(DIM_THREE, 32767, -32768, 32767, -32768, 32767, -32768);
    queue_pair(DIM_SPARE, -32768, -32768, -32768, 32767, 32767, 32767);
    // Unused axes carry far-apart values that must not change the answer.
    queue_pair(DIM_ONE,   16, -32768, 32767, 48, 32767, -32768);
    queue_pair(DIM_TWO,   0, 0, -32768, 48, 64, 32767);
    // An exact root in 3D, and sums in 2D and 3D that fall between two squares.
    queue_pair(DIM_THREE, 0, 0, 0, 32, 48, 96);
    queue_pair(DIM_TWO,   0, 0, 0, 1, 1, 0);
    queue_pair(DIM_THREE, 0, 0, 0, 1, 1, 1);
    queue_pair(DIM_TWO,   -1, -1, 0, 1, 2, 0);
    // The spare code uses z just as 3D does.
    queue_pair(DIM_SPARE, 0, 0, 0, 0, 0, -1);
    queue_pair(DIM_SPARE, 100, -200, 300, -400, 500, -600);
    // Alternating bit patterns through every coordinate field.
    queue_pair(DIM_THREE, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA);
    queue_pair(DIM_TWO,   'hAAAA, 'h5555, 'hFFFF, 'h5555, 'hAAAA, 'h0000);
    wait_drained();

    for (ph = 0; ph < PHASES; ph++) begin
      // Phase 0 runs back to back on both sides; the others mix in gaps on one or both sides. In
      // phase 2 the sender streams while the receiver stops for a long stretch.
      send_idle = (ph == 1 || ph == 3 || ph == 4);
      recv_idle = (ph == 1 || ph == 2 || ph == 4);
      for (k = 0; k < PHASE_PAIRS; k++)
        pending_pairs.push_back(random_pair());
      if (ph == 2) begin
        repeat (10) @(negedge clk);
        hold_asks = hold_asks + 1;
      end
      wait_drained();
    end

    repeat (DRAIN_TICKS) @(posedge clk);
    if (owed_distances.size() != 0)
      $error("distance: %0d results never arrived", owed_distances.size());

    $display("Run covered %0d point pairs (1D %0d, 2D %0d, 3D %0d, spare code %0d).",
             pairs_taken, dim_count[0], dim_count[1], dim_count[2], dim_count[3]);
    $display("%0d distances checked with %0d mismatches.", distances_checked, errors);
    if (errors == 0 && owed_distances.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
